FILE: hw/rtl/mpre_pkg.sv
package mpre_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 64;
   localparam int SORT_DEPTH  = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
   localparam int EFF_DEPTH   = SORT_DEPTH;
   localparam int EFF_AW      = $clog2(EFF_DEPTH);
   localparam int STORE_DEPTH = 4096;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int DIM_W       = 7;
   localparam int DATA_W      = 32;
   localparam int WIDE_W      = DATA_W + 3;
   localparam int SUM_W       = 40;
   localparam int PROD_W      = 48;

   localparam logic [1:0] CSR_ROW_COUNT         = 2'd0;
   localparam logic [1:0] CSR_COLUMN_COUNT      = 2'd1;
   localparam logic [1:0] CSR_ITERATION_LIMIT   = 2'd2;
   localparam logic [1:0] CSR_CONVERGENCE_LIMIT = 2'd3;

   typedef enum logic [4:0] {
      S_LOAD,
      S_CLEAR,
      S_COLHEAD,
      S_COLCAP,
      S_COLRD,
      S_COLWR,
      S_CMRD,
      S_DRAIN,
      S_SHIFT,
      S_CSUB,
      S_ROWHEAD,
      S_ROWCAP,
      S_ROWRD,
      S_ROWWR,
      S_PDRAIN,
      S_CONV1,
      S_CONV2,
      S_OUTRD,
      S_OUTLD,
      S_OUTWAIT
   } state_type;

   typedef enum logic [1:0] {
      PHASE_COL,
      PHASE_CMED,
      PHASE_ROW
   } phase_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } sort_ctl_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = $signed({{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
      lo = $signed({{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
      if (v > hi) begin
         return hi[DATA_W-1:0];
      end else if (v < lo) begin
         return lo[DATA_W-1:0];
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [WIDE_W-1:0] widen(input logic signed [DATA_W-1:0] v);
      return $signed({{(WIDE_W-DATA_W){v[DATA_W-1]}}, v});
   endfunction

endpackage

FILE: hw/rtl/median_polish_row_effects.sv
// Loading takes one element per cycle; the last element starts the polish.
// The polish first clears the effects, then runs passes whose pace is set by the
// single matrix memory port and the insertion sorter that takes one value a cycle.
// Results then leave one row at a time, each held on rsp_valid until rsp_ready takes it.
// Synchronous reset returns the control registers and CSRs to their defaults and
// the block to loading; the datapath registers are not reset.
module median_polish_row_effects import mpre_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_element_value,
   input  logic                     req_last_element,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_row_effect,
   output logic [EFF_AW-1:0]        rsp_row_number,
   output logic                     rsp_last_row,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [30:0]              csr_write_data
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [DIM_W-1:0]   rc_ff, cc_ff;
   logic [7:0]         il_ff;
   logic [30:0]        cl_ff;
   logic [DIM_W-1:0]   rows_ff, rows_in, cols_ff, cols_in;
   logic [7:0]         limit_ff, limit_in, passes_ff, passes_in;
   logic [STORE_AW-1:0] load_pos_ff, load_pos_in;
   logic [DIM_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic [STORE_AW-1:0] addr_ff, addr_in, base_ff, base_in;
   logic [EFF_AW-1:0]  k_ff, k_in, half;

   logic signed [DATA_W-1:0] cj_ff, cj_in, a_ff, a_in, rprev_ff, rprev_in;
   logic signed [DATA_W-1:0] med_ff, med_in, m_ff, m_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic                     rd_vld_ff, rd_vld_in, res_vld_ff;
   logic                     csub_vld_ff, csub_vld_in;
   logic [EFF_AW-1:0]        csub_addr_ff, csub_addr_in;

   logic                     acc_vld, acc_sel;
   logic signed [DATA_W-1:0] acc_a, acc_b;
   logic                     d_vld_ff, d_sel_ff, ad_vld_ff, ad_sel_ff;
   logic signed [DATA_W:0]   d_ff;
   logic [DATA_W:0]          ad_ff;
   logic [SUM_W-1:0]         rs_ff, rs_in, cs_ff, cs_in;
   logic [PROD_W-1:0]        prow_ff, pcol_ff, total;

   logic                     rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic signed [DATA_W-1:0] rsp_effect_ff, rsp_effect_in;
   logic [EFF_AW-1:0]        rsp_number_ff, rsp_number_in;

   logic                     m_we;
   logic [STORE_AW-1:0]      m_raddr;
   logic [DATA_W-1:0]        m_rdata_raw;
   logic                     r_we, c_we, p_we;
   logic [EFF_AW-1:0]        r_waddr, r_raddr, c_waddr, c_raddr, p_raddr;
   logic signed [DATA_W-1:0] r_wdata, c_wdata;
   logic [DATA_W-1:0]        r_rdata_raw, c_rdata_raw, p_rdata_raw;
   logic signed [DATA_W-1:0] m_rdata, r_rdata, c_rdata, p_rdata;
   logic signed [DATA_W-1:0] rterm, cterm, cnew, median;
   logic [DIM_W-1:0]         rows_clamped, cols_clamped;
   logic                     req_fire, stage_busy, acc_busy;
   sort_ctl_type             sort_ctl;

   assign m_rdata = $signed(m_rdata_raw);
   assign r_rdata = $signed(r_rdata_raw);
   assign c_rdata = $signed(c_rdata_raw);
   assign p_rdata = $signed(p_rdata_raw);

   mpre_ram #(.DEPTH(STORE_DEPTH), .WIDTH(DATA_W)) u_matrix (
      .clock(clock), .write_enable(m_we), .write_address(load_pos_ff),
      .write_data(req_element_value), .read_address(m_raddr), .read_data(m_rdata_raw)
   );
   mpre_ram #(.DEPTH(EFF_DEPTH), .WIDTH(DATA_W)) u_row_eff (
      .clock(clock), .write_enable(r_we), .write_address(r_waddr),
      .write_data(r_wdata), .read_address(r_raddr), .read_data(r_rdata_raw)
   );
   mpre_ram #(.DEPTH(EFF_DEPTH), .WIDTH(DATA_W)) u_col_eff (
      .clock(clock), .write_enable(c_we), .write_address(c_waddr),
      .write_data(c_wdata), .read_address(c_raddr), .read_data(c_rdata_raw)
   );
   mpre_ram #(.DEPTH(EFF_DEPTH), .WIDTH(DATA_W)) u_prev_col (
      .clock(clock), .write_enable(p_we), .write_address(c_waddr),
      .write_data(cj_ff), .read_address(p_raddr), .read_data(p_rdata_raw)
   );

   mpre_median u_median (
      .clock(clock), .reset(reset), .ctl(sort_ctl), .value(res_ff), .median(median)
   );

   assign req_ready      = (state_ff == S_LOAD);
   assign req_fire       = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_effect = rsp_effect_ff;
   assign rsp_row_number = rsp_number_ff;
   assign rsp_last_row   = rsp_last_ff;
   assign stage_busy     = rd_vld_ff || res_vld_ff;
   assign acc_busy       = d_vld_ff || ad_vld_ff;
   assign total          = prow_ff + pcol_ff;

   always_comb begin
      rows_clamped = rc_ff;
      if (rc_ff == '0) begin
         rows_clamped = DIM_W'(1);
      end else if (rc_ff > DIM_W'(MAX_ROWS)) begin
         rows_clamped = DIM_W'(MAX_ROWS);
      end
      cols_clamped = cc_ff;
      if (cc_ff == '0) begin
         cols_clamped = DIM_W'(1);
      end else if (cc_ff > DIM_W'(MAX_COLUMNS)) begin
         cols_clamped = DIM_W'(MAX_COLUMNS);
      end
   end

   always_comb begin
      rterm  = (phase_ff == PHASE_ROW) ? a_ff : r_rdata;
      cterm  = (phase_ff == PHASE_ROW) ? c_rdata : cj_ff;
      res_in = (phase_ff == PHASE_CMED) ? c_rdata
             : sat32(widen(m_rdata) - widen(rterm) - widen(cterm));
      cnew   = sat32(widen(c_rdata) - widen(m_ff));
      half   = (phase_ff == PHASE_COL) ? EFF_AW'((rows_ff - 1'b1) >> 1)
                                       : EFF_AW'((cols_ff - 1'b1) >> 1);
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      limit_in      = limit_ff;
      passes_in     = passes_ff;
      load_pos_in   = load_pos_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      addr_in       = addr_ff;
      base_in       = base_ff;
      k_in          = k_ff;
      cj_in         = cj_ff;
      a_in          = a_ff;
      rprev_in      = rprev_ff;
      med_in        = med_ff;
      m_in          = m_ff;
      rd_vld_in     = 1'b0;
      csub_vld_in   = 1'b0;
      csub_addr_in  = csub_addr_ff;
      rs_in         = rs_ff;
      cs_in         = cs_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_effect_in = rsp_effect_ff;
      rsp_number_in = rsp_number_ff;
      rsp_last_in   = rsp_last_ff;
      m_we          = 1'b0;
      m_raddr       = addr_ff;
      r_we          = 1'b0;
      r_waddr       = i_ff[EFF_AW-1:0];
      r_wdata       = '0;
      r_raddr       = i_ff[EFF_AW-1:0];
      c_we          = 1'b0;
      c_waddr       = j_ff[EFF_AW-1:0];
      c_wdata       = '0;
      c_raddr       = j_ff[EFF_AW-1:0];
      p_we          = 1'b0;
      p_raddr       = j_ff[EFF_AW-1:0];
      sort_ctl      = '{clear: 1'b0, insert: res_vld_ff, shift: 1'b0};
      acc_vld       = 1'b0;
      acc_sel       = 1'b0;
      acc_a         = '0;
      acc_b         = '0;

      if (d_vld_ff) begin
         if (d_sel_ff) begin
            rs_in = rs_ff;
         end
      end
      if (ad_vld_ff) begin
         if (ad_sel_ff) begin
            rs_in = rs_ff + SUM_W'(ad_ff);
         end else begin
            cs_in = cs_ff + SUM_W'(ad_ff);
         end
      end

      if (csub_vld_ff) begin
         c_we    = 1'b1;
         c_waddr = csub_addr_ff;
         c_wdata = cnew;
         acc_vld = 1'b1;
         acc_sel = 1'b0;
         acc_a   = cnew;
         acc_b   = p_rdata;
      end

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               m_we        = 1'b1;
               load_pos_in = load_pos_ff + 1'b1;
               if (req_last_element) begin
                  load_pos_in = '0;
                  rows_in     = rows_clamped;
                  cols_in     = cols_clamped;
                  limit_in    = (il_ff == '0) ? 8'd1 : il_ff;
                  i_in        = '0;
                  state_in    = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            r_we    = 1'b1;
            c_we    = 1'b1;
            c_waddr = i_ff[EFF_AW-1:0];
            i_in    = i_ff + 1'b1;
            if (i_ff == DIM_W'(EFF_DEPTH - 1)) begin
               j_in      = '0;
               passes_in = '0;
               rs_in     = '0;
               cs_in     = '0;
               state_in  = S_COLHEAD;
            end
         end
         S_COLHEAD: begin
            state_in = S_COLCAP;
         end
         S_COLCAP: begin
            cj_in          = c_rdata;
            i_in           = '0;
            addr_in        = STORE_AW'(j_ff);
            phase_in       = PHASE_COL;
            sort_ctl.clear = 1'b1;
            state_in       = S_COLRD;
         end
         S_COLRD: begin
            rd_vld_in = 1'b1;
            addr_in   = addr_ff + STORE_AW'(cols_ff);
            i_in      = i_ff + 1'b1;
            if (i_ff == rows_ff - 1'b1) begin
               state_in = S_DRAIN;
            end
         end
         S_COLWR: begin
            c_we    = 1'b1;
            c_wdata = sat32(widen(cj_ff) + widen(med_ff));
            p_we    = 1'b1;
            if (j_ff == cols_ff - 1'b1) begin
               j_in           = '0;
               phase_in       = PHASE_CMED;
               sort_ctl.clear = 1'b1;
               state_in       = S_CMRD;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_COLHEAD;
            end
         end
         S_CMRD: begin
            rd_vld_in = 1'b1;
            j_in      = j_ff + 1'b1;
            if (j_ff == cols_ff - 1'b1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stage_busy) begin
               k_in     = '0;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (k_ff != half) begin
               sort_ctl.shift = 1'b1;
               k_in           = k_ff + 1'b1;
            end else begin
               med_in = median;
               case (phase_ff)
                  PHASE_COL: begin
                     state_in = S_COLWR;
                  end
                  PHASE_CMED: begin
                     m_in     = median;
                     j_in     = '0;
                     state_in = S_CSUB;
                  end
                  default: begin
                     state_in = S_ROWWR;
                  end
               endcase
            end
         end
         S_CSUB: begin
            csub_vld_in  = 1'b1;
            csub_addr_in = j_ff[EFF_AW-1:0];
            j_in         = j_ff + 1'b1;
            if (j_ff == cols_ff - 1'b1) begin
               i_in     = '0;
               base_in  = '0;
               state_in = S_ROWHEAD;
            end
         end
         S_ROWHEAD: begin
            state_in = S_ROWCAP;
         end
         S_ROWCAP: begin
            rprev_in       = r_rdata;
            a_in           = sat32(widen(r_rdata) + widen(m_ff));
            j_in           = '0;
            addr_in        = base_ff;
            phase_in       = PHASE_ROW;
            sort_ctl.clear = 1'b1;
            state_in       = S_ROWRD;
         end
         S_ROWRD: begin
            rd_vld_in = 1'b1;
            addr_in   = addr_ff + 1'b1;
            j_in      = j_ff + 1'b1;
            if (j_ff == cols_ff - 1'b1) begin
               state_in = S_DRAIN;
            end
         end
         S_ROWWR: begin
            r_we    = 1'b1;
            r_wdata = sat32(widen(a_ff) + widen(med_ff));
            acc_vld = 1'b1;
            acc_sel = 1'b1;
            acc_a   = r_wdata;
            acc_b   = rprev_ff;
            base_in = base_ff + STORE_AW'(cols_ff);
            if (i_ff == rows_ff - 1'b1) begin
               passes_in = passes_ff + 1'b1;
               state_in  = S_PDRAIN;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_ROWHEAD;
            end
         end
         S_PDRAIN: begin
            if (!acc_busy) begin
               state_in = S_CONV1;
            end
         end
         S_CONV1: begin
            state_in = S_CONV2;
         end
         S_CONV2: begin
            if ((total < PROD_W'(cl_ff)) || (passes_ff >= limit_ff)) begin
               i_in     = '0;
               state_in = S_OUTRD;
            end else begin
               rs_in    = '0;
               cs_in    = '0;
               j_in     = '0;
               state_in = S_COLHEAD;
            end
         end
         S_OUTRD: begin
            state_in = S_OUTLD;
         end
         S_OUTLD: begin
            rsp_valid_in  = 1'b1;
            rsp_effect_in = r_rdata;
            rsp_number_in = i_ff[EFF_AW-1:0];
            rsp_last_in   = (i_ff == rows_ff - 1'b1);
            state_in      = S_OUTWAIT;
         end
         S_OUTWAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_LOAD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_OUTRD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         phase_ff     <= PHASE_COL;
         rc_ff        <= DIM_W'(64);
         cc_ff        <= DIM_W'(64);
         il_ff        <= 8'd10;
         cl_ff        <= 31'd655;
         load_pos_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         res_vld_ff   <= 1'b0;
         csub_vld_ff  <= 1'b0;
         d_vld_ff     <= 1'b0;
         ad_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         passes_ff    <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         load_pos_ff  <= load_pos_in;
         rd_vld_ff    <= rd_vld_in;
         res_vld_ff   <= rd_vld_ff;
         csub_vld_ff  <= csub_vld_in;
         d_vld_ff     <= acc_vld;
         ad_vld_ff    <= d_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         passes_ff    <= passes_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROW_COUNT:         rc_ff <= csr_write_data[DIM_W-1:0];
               CSR_COLUMN_COUNT:      cc_ff <= csr_write_data[DIM_W-1:0];
               CSR_ITERATION_LIMIT:   il_ff <= csr_write_data[7:0];
               CSR_CONVERGENCE_LIMIT: cl_ff <= csr_write_data;
               default:               cl_ff <= cl_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rows_ff       <= rows_in;
      cols_ff       <= cols_in;
      limit_ff      <= limit_in;
      addr_ff       <= addr_in;
      base_ff       <= base_in;
      cj_ff         <= cj_in;
      a_ff          <= a_in;
      rprev_ff      <= rprev_in;
      med_ff        <= med_in;
      m_ff          <= m_in;
      res_ff        <= res_in;
      csub_addr_ff  <= csub_addr_in;
      d_ff          <= $signed({acc_a[DATA_W-1], acc_a}) - $signed({acc_b[DATA_W-1], acc_b});
      d_sel_ff      <= acc_sel;
      ad_ff         <= d_ff[DATA_W] ? $unsigned(-d_ff) : $unsigned(d_ff);
      ad_sel_ff     <= d_sel_ff;
      rs_ff         <= rs_in;
      cs_ff         <= cs_in;
      prow_ff       <= PROD_W'(rs_ff) * PROD_W'(cols_ff);
      pcol_ff       <= PROD_W'(cs_ff) * PROD_W'(rows_ff);
      rsp_effect_ff <= rsp_effect_in;
      rsp_number_ff <= rsp_number_in;
      rsp_last_ff   <= rsp_last_in;
   end

`ifndef SYNTH
   a_rsp_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OUTWAIT))
      else $error("result shown outside the output wait");

   a_no_shift_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (!rd_vld_ff && !res_vld_ff))
      else $error("sorter shifted while a value was still in flight");

   a_sums_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV1) |-> (!d_vld_ff && !ad_vld_ff && !csub_vld_ff))
      else $error("convergence measure taken before the change sums settled");

   a_last_starts_polish: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_element) |=> (state_ff == S_CLEAR))
      else $error("last element did not start the polish");
`endif

endmodule

FILE: hw/rtl/mpre_ram.sv
module mpre_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

FILE: hw/rtl/mpre_median.sv
module mpre_median import mpre_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  sort_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] value,
   output logic signed [DATA_W-1:0] median
);

   logic signed [DATA_W-1:0] cell_ff [SORT_DEPTH];
   logic signed [DATA_W-1:0] cell_in [SORT_DEPTH];
   logic [DIM_W-1:0]         count_ff;
   logic [DIM_W-1:0]         count_in;
   logic [SORT_DEPTH-1:0]    below;
   logic signed [DATA_W:0]   pair_sum;

   always_comb begin
      for (int k = 0; k < SORT_DEPTH; k++) begin
         below[k] = (DIM_W'(k) < count_ff) && (cell_ff[k] <= value);
      end
      for (int k = 0; k < SORT_DEPTH; k++) begin
         cell_in[k] = cell_ff[k];
      end
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.insert) begin
         count_in = count_ff + 1'b1;
         if (!below[0]) begin
            cell_in[0] = value;
         end
         for (int k = 1; k < SORT_DEPTH; k++) begin
            if (!below[k]) begin
               cell_in[k] = below[k-1] ? value : cell_ff[k-1];
            end
         end
      end else if (ctl.shift) begin
         for (int k = 0; k < SORT_DEPTH - 1; k++) begin
            cell_in[k] = cell_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SORT_DEPTH; k++) begin
         cell_ff[k] <= cell_in[k];
      end
   end

   assign pair_sum = $signed({cell_ff[0][DATA_W-1], cell_ff[0]})
                   + $signed({cell_ff[1][DATA_W-1], cell_ff[1]});
   assign median   = count_ff[0] ? cell_ff[0] : pair_sum[DATA_W:1];

endmodule

FILE: tb/sv/median_polish_row_effects_checker.sv
module median_polish_row_effects_checker import mpre_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_element_value,
   input  logic                     req_last_element,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [DATA_W-1:0] rsp_row_effect,
   input  logic [EFF_AW-1:0]        rsp_row_number,
   input  logic                     rsp_last_row,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [30:0]              csr_write_data,
   output int                       pending_rows,
   output int                       failures,
   output int                       rows_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [DATA_W-1:0] effect;
      logic [EFF_AW-1:0]        number;
      logic                     last;
   } row_result_type;

   row_result_type expected_rows[$];

   logic [6:0]  rows_reg;
   logic [6:0]  cols_reg;
   logic [7:0]  iter_reg;
   logic [30:0] conv_reg;

   int unsigned load_pos;
   int          matrix[STORE_DEPTH];
   int          row_eff[MAX_ROWS];
   int          col_eff[MAX_COLUMNS];

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic int median_of(input int vals[SORT_DEPTH], input int n);
      int k;
      int v;
      for (int i = 1; i < n; i++) begin
         v = vals[i];
         k = i;
         while (k > 0 && vals[k-1] > v) begin
            vals[k] = vals[k-1];
            k--;
         end
         vals[k] = v;
      end
      if (n % 2 == 1) return vals[(n-1)/2];
      return int'((longint'(vals[n/2-1]) + longint'(vals[n/2])) >>> 1);
   endfunction

   function automatic int residual(int i, int j, int cols);
      return clamp32(longint'(matrix[(i*cols + j) % STORE_DEPTH])
                     - longint'(row_eff[i]) - longint'(col_eff[j]));
   endfunction

   function automatic void predict_row_effects();
      int             rows;
      int             cols;
      int             lim;
      int             passes;
      int             m;
      int             work[SORT_DEPTH];
      int             prev_row[MAX_ROWS];
      int             prev_col[MAX_COLUMNS];
      longint         d;
      logic [63:0]    row_change;
      logic [63:0]    col_change;
      logic [63:0]    measure;
      bit             done;
      row_result_type r;
      rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
      cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
      lim = (iter_reg == 0) ? 1 : int'(iter_reg);
      foreach (row_eff[i]) row_eff[i] = 0;
      foreach (col_eff[i]) col_eff[i] = 0;
      foreach (work[i]) work[i] = 0;
      passes = 0;
      done = 0;
      while (!done) begin
         prev_row = row_eff;
         prev_col = col_eff;
         for (int j = 0; j < cols; j++) begin
            for (int i = 0; i < rows; i++) work[i] = residual(i, j, cols);
            col_eff[j] = clamp32(longint'(col_eff[j]) + median_of(work, rows));
         end
         for (int j = 0; j < cols; j++) work[j] = col_eff[j];
         m = median_of(work, cols);
         for (int i = 0; i < rows; i++) row_eff[i] = clamp32(longint'(row_eff[i]) + m);
         for (int j = 0; j < cols; j++) col_eff[j] = clamp32(longint'(col_eff[j]) - m);
         for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) work[j] = residual(i, j, cols);
            row_eff[i] = clamp32(longint'(row_eff[i]) + median_of(work, cols));
         end
         passes++;
         row_change = 0;
         col_change = 0;
         for (int i = 0; i < rows; i++) begin
            d = longint'(prev_row[i]) - longint'(row_eff[i]);
            row_change += (d < 0) ? -d : d;
         end
         for (int j = 0; j < cols; j++) begin
            d = longint'(prev_col[j]) - longint'(col_eff[j]);
            col_change += (d < 0) ? -d : d;
         end
         measure = row_change * cols + col_change * rows;
         if (measure < {33'd0, conv_reg} || passes >= lim) done = 1;
      end
      for (int i = 0; i < rows; i++) begin
         r.effect = row_eff[i];
         r.number = i[EFF_AW-1:0];
         r.last = (i == rows - 1);
         expected_rows.insert(expected_rows.size(), r);
      end
   endfunction

   always @(posedge clock) begin
      row_result_type e;
      if (reset) begin
         rows_reg <= 7'd64;
         cols_reg <= 7'd64;
         iter_reg <= 8'd10;
         conv_reg <= 31'd655;
         load_pos = 0;
         expected_rows.delete();
         pending_rows <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROW_COUNT: begin
                  rows_reg <= csr_write_data[6:0];
               end
               CSR_COLUMN_COUNT: begin
                  cols_reg <= csr_write_data[6:0];
               end
               CSR_ITERATION_LIMIT: begin
                  iter_reg <= csr_write_data[7:0];
               end
               CSR_CONVERGENCE_LIMIT: begin
                  conv_reg <= csr_write_data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            rows_checked <= rows_checked + 1;
            if (expected_rows.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("unexpected row result: row %0d effect %0d",
                           rsp_row_number, rsp_row_effect);
               end
            end else begin
               e = expected_rows.pop_front();
               if (e.effect !== rsp_row_effect || e.number !== rsp_row_number
                   || e.last !== rsp_last_row) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("row result mismatch: expected row %0d effect %0d last %0b,",
                              e.number, e.effect, e.last);
                     $display("   got row %0d effect %0d last %0b",
                              rsp_row_number, rsp_row_effect, rsp_last_row);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            if (load_pos < STORE_DEPTH) matrix[load_pos] = req_element_value;
            load_pos = (load_pos + 1) % STORE_DEPTH;
            if (req_last_element) begin
               predict_row_effects();
               load_pos = 0;
            end
         end
         pending_rows <= expected_rows.size();
      end
   end

   initial begin
      failures = 0;
      rows_checked = 0;
      pending_rows = 0;
   end

endmodule

FILE: tb/sv/tb_median_polish_row_effects.sv
module tb_median_polish_row_effects;
   import mpre_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_element_value;
   logic                     req_last_element;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_row_effect;
   logic [EFF_AW-1:0]        rsp_row_number;
   logic                     rsp_last_row;
   logic                     csr_write_enable;
   logic [1:0]               csr_index;
   logic [30:0]              csr_write_data;

   int pending_rows;
   int failures;
   int rows_checked;
   int cycles;
   int elements_sent;
   int matrices_sent;
   int store_filled;
   int rows_now;
   int cols_now;
   bit quiet;

   median_polish_row_effects dut (.*);

   median_polish_row_effects_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
   end

   task automatic wait_idle();
      @(posedge clock);
      while (pending_rows != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [30:0] value, int width);
      logic [30:0] noise;
      noise = 31'($urandom);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= (noise & ~((31'd1 << width) - 1)) | value;
      @(posedge clock);
   endtask

   task automatic configure(int rows, int cols, int lim, logic [30:0] conv);
      wait_idle();
      write_reg(CSR_ROW_COUNT, 31'(rows), 7);
      write_reg(CSR_COLUMN_COUNT, 31'(cols), 7);
      write_reg(CSR_ITERATION_LIMIT, 31'(lim), 8);
      write_reg(CSR_CONVERGENCE_LIMIT, conv, 31);
      csr_write_enable <= 1'b0;
      rows_now = (rows == 0) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : rows;
      cols_now = (cols == 0) ? 1 : (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
   endtask

   task automatic send_element(logic [31:0] value, logic last);
      if (!quiet) begin
         while ($urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_element_value <= value;
      req_last_element <= last;
      do @(posedge clock); while (!req_ready);
      if (last) req_valid <= 1'b0;
      elements_sent++;
      if (last) matrices_sent++;
   endtask

   function automatic logic [31:0] pick_value(int style);
      case (style)
         0: return $urandom;
         1: begin
            case ($urandom_range(3))
               0: return 32'h7FFFFFFF;
               1: return 32'h80000000;
               2: return 32'hFFFFFFFF;
               default: return 32'h0;
            endcase
         end
         default: return 32'($signed($urandom_range(2097152)) - 1048576);
      endcase
   endfunction

   task automatic send_matrix(int count, int style);
      for (int k = 0; k < count; k++) begin
         send_element(pick_value(style), k == count - 1);
      end
      if (count > store_filled) store_filled = (count > STORE_DEPTH) ? STORE_DEPTH : count;
   endtask

   task automatic send_directed(logic [31:0] vals[$]);
      foreach (vals[k]) send_element(vals[k], k == vals.size() - 1);
      if (vals.size() > store_filled) store_filled = vals.size();
   endtask

   initial begin
      int rows;
      int cols;
      int lim;
      int len;
      int full;
      logic [30:0] conv;
      cycles = 0;
      elements_sent = 0;
      matrices_sent = 0;
      store_filled = 0;
      quiet = 1'b0;
      rows_now = MAX_ROWS;
      cols_now = MAX_COLUMNS;
      reset = 1'b1;
      req_valid = 1'b0;
      req_element_value = '0;
      req_last_element = 1'b0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_ROW_COUNT;
      csr_write_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(1, 1, 0, 31'd0);
      send_directed('{32'h7FFFFFFF});
      configure(2, 2, 1, 31'd655);
      send_directed('{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0});
      configure(3, 3, 255, 31'h7FFFFFFF);
      send_directed('{32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFF0000,
                      32'h0, 32'h80000000, 32'h00008000, 32'h7FFFFFFF, 32'h1});
      configure(2, 3, 255, 31'd0);
      send_directed('{32'h00030000, 32'h80000001, 32'h7FFFFFFE,
                      32'hFFFFFFFE, 32'h00000005, 32'h00020000});

      while (elements_sent < 430) begin
         quiet = (matrices_sent >= 12 && matrices_sent < 20);
         case ($urandom_range(9))
            0: begin
               rows = ($urandom_range(1)) ? 0 : $urandom_range(64, 127);
               cols = $urandom_range(1, 2);
            end
            1: begin
               rows = $urandom_range(1, 2);
               cols = ($urandom_range(1)) ? 0 : $urandom_range(64, 127);
            end
            default: begin
               rows = $urandom_range(1, 8);
               cols = $urandom_range(1, 8);
            end
         endcase
         case ($urandom_range(9))
            0: lim = 0;
            1: lim = (rows * cols <= 9) ? 255 : 12;
            default: lim = $urandom_range(1, 12);
         endcase
         case ($urandom_range(4))
            0: conv = 31'd0;
            1: conv = 31'h7FFFFFFF;
            2: conv = 31'd655;
            default: conv = $urandom_range(200000);
         endcase
         configure(rows, cols, lim, conv);
         full = rows_now * cols_now;
         len = full;
         if ($urandom_range(9) == 0) begin
            len = $urandom_range(1, full + 3);
            if (len < full && full > store_filled) len = full;
         end
         send_matrix(len, $urandom_range(3));
      end
      quiet = 1'b0;

      @(posedge clock);
      while (pending_rows != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("Sent %0d elements in %0d matrices; checked %0d row effects.",
               elements_sent, matrices_sent, rows_checked);
      $display("Shapes ran from one element to 64 rows or columns, with and without stalls.");
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: median_polish_row_effects.f
hw/rtl/mpre_pkg.sv
hw/rtl/mpre_ram.sv
hw/rtl/mpre_median.sv
hw/rtl/median_polish_row_effects.sv
tb/sv/median_polish_row_effects_checker.sv
tb/sv/tb_median_polish_row_effects.sv
